// ----- rtl/hfam_pkg.sv -----
// Shared types and constants for the half float add/multiply queue.
package hfam_pkg;

    localparam int RING_DEPTH = 10;
    localparam int RING_IW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int OUT_DEPTH  = 3;

    localparam int ALIGN_W = 42;
    localparam int SUM_W   = 43;

    localparam logic [4:0]        EXP_MAX   = 5'd31;
    localparam logic [9:0]        FRAC_ONES = 10'h3ff;
    localparam logic signed [7:0] ADD_EOFS  = -8'sd10;
    localparam logic signed [7:0] MUL_BIAS  = 8'sd35;

    typedef enum logic {
        MODE_ADD = 1'b0,
        MODE_MUL = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] a;
        logic [15:0] b;
        logic        rd;
    } t_tag;

endpackage

// ----- rtl/half_float_add_mul_queue.sv -----
// Half float add/multiply queue: top level with the two result rings and the output queue.
// One item is taken per clock while o_s_axis_tready is high. Each item is added or multiplied
// (mode), rounded, and pushed with its operands into that mode's 10-entry ring; with read_enable
// the same item also pops the entry at that ring's read pointer, which then leaves on the master
// side. The latency is set by the four-stage arithmetic pipeline plus the ring read and the
// output queue write. A three-entry output queue lets items keep flowing while a result waits;
// the input is held off only when that queue could otherwise overflow.
module half_float_add_mul_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // mode, a_bits, b_bits, read_enable, zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // result_bits, a_echo, b_echo
);

    localparam int IW = hfam_pkg::RING_IW;

    logic           en;
    hfam_pkg::t_tag in_tag, f_tag;
    logic           f_v;
    logic [15:0]    f_res;

    logic [1:0] r_cnt, r_head;
    logic       r_rd_v;

    assign en = ({1'b0, r_cnt} + {2'd0, r_rd_v}) < 3'(hfam_pkg::OUT_DEPTH);
    assign o_s_axis_tready = en;

    always_comb begin
        in_tag.mode = hfam_pkg::t_mode'(i_s_axis_tdata[0]);
        in_tag.a    = i_s_axis_tdata[16:1];
        in_tag.b    = i_s_axis_tdata[32:17];
        in_tag.rd   = i_s_axis_tdata[33];
    end

    hfam_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_tag   (in_tag),
        .o_valid (f_v),
        .o_tag   (f_tag),
        .o_res   (f_res)
    );

    // rings
    logic [47:0] add_ring [hfam_pkg::RING_DEPTH];
    logic [47:0] mul_ring [hfam_pkg::RING_DEPTH];
    logic [hfam_pkg::RING_DEPTH-1:0] r_add_vld, r_mul_vld;
    logic [IW-1:0] r_add_wi, r_add_ri, r_mul_wi, r_mul_ri;
    logic [IW-1:0] wi, ri;
    logic          go, is_mul, wr_add, wr_mul, rd_add, rd_mul;
    logic [47:0]   wdata;

    logic [47:0] r_add_q, r_mul_q, r_fwd_d;
    logic        r_add_qv, r_mul_qv, r_fwd, r_q_mul;
    logic [47:0] rd_data;

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
        return (x == IW'(hfam_pkg::RING_DEPTH - 1)) ? '0 : x + IW'(1);
    endfunction

    always_comb begin
        go     = en && f_v;
        is_mul = (f_tag.mode == hfam_pkg::MODE_MUL);
        wr_add = go && !is_mul;
        wr_mul = go && is_mul;
        rd_add = wr_add && f_tag.rd;
        rd_mul = wr_mul && f_tag.rd;
        wi     = is_mul ? r_mul_wi : r_add_wi;
        ri     = is_mul ? r_mul_ri : r_add_ri;
        wdata  = {f_tag.b, f_tag.a, f_res};
    end

    always_ff @(posedge i_clk) begin
        if (wr_add) begin
            add_ring[r_add_wi] <= wdata;
        end
        if (rd_add) begin
            r_add_q <= add_ring[r_add_ri];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_mul) begin
            mul_ring[r_mul_wi] <= wdata;
        end
        if (rd_mul) begin
            r_mul_q <= mul_ring[r_mul_ri];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_vld <= '0;
            r_mul_vld <= '0;
            r_add_wi  <= '0;
            r_add_ri  <= '0;
            r_mul_wi  <= '0;
            r_mul_ri  <= '0;
            r_rd_v    <= 1'b0;
        end else begin
            if (wr_add) begin
                r_add_vld[r_add_wi] <= 1'b1;
                r_add_wi            <= inc_idx(r_add_wi);
            end
            if (wr_mul) begin
                r_mul_vld[r_mul_wi] <= 1'b1;
                r_mul_wi            <= inc_idx(r_mul_wi);
            end
            if (rd_add) begin
                r_add_ri <= inc_idx(r_add_ri);
            end
            if (rd_mul) begin
                r_mul_ri <= inc_idx(r_mul_ri);
            end
            r_rd_v <= rd_add || rd_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_add || rd_mul) begin
            r_q_mul  <= is_mul;
            r_fwd    <= (wi == ri);
            r_fwd_d  <= wdata;
            r_add_qv <= r_add_vld[r_add_ri];
            r_mul_qv <= r_mul_vld[r_mul_ri];
        end
    end

    always_comb begin
        if (r_fwd) begin
            rd_data = r_fwd_d;
        end else if (r_q_mul) begin
            rd_data = r_mul_qv ? r_mul_q : '0;
        end else begin
            rd_data = r_add_qv ? r_add_q : '0;
        end
    end

    // output queue
    logic [47:0] r_fq [hfam_pkg::OUT_DEPTH];
    logic        pop;
    logic [1:0]  tail;
    logic [2:0]  tail_sum;

    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = r_fq[r_head];

    always_comb begin
        tail_sum = {1'b0, r_head} + {1'b0, r_cnt};
        if (tail_sum >= 3'(hfam_pkg::OUT_DEPTH)) begin
            tail_sum = tail_sum - 3'(hfam_pkg::OUT_DEPTH);
        end
        tail = tail_sum[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_fq[tail] <= rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, r_rd_v} - {1'b0, pop};
            if (pop) begin
                r_head <= (r_head == 2'(hfam_pkg::OUT_DEPTH - 1)) ? 2'd0 : r_head + 2'd1;
            end
        end
    end

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_cnt < 2'(hfam_pkg::OUT_DEPTH)))
        else $error("output queue overflow");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(hfam_pkg::OUT_DEPTH))
        else $error("output queue count out of range");

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_add || rd_mul) |=> r_rd_v)
        else $error("ring read lost");

    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_add_wi < IW'(hfam_pkg::RING_DEPTH) && r_add_ri < IW'(hfam_pkg::RING_DEPTH) &&
        r_mul_wi < IW'(hfam_pkg::RING_DEPTH) && r_mul_ri < IW'(hfam_pkg::RING_DEPTH))
        else $error("ring index out of range");

endmodule

// ----- rtl/hfam_arith.sv -----
// Four-stage half float add/multiply datapath with exact result and round half away.
module hfam_arith (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hfam_pkg::t_tag    i_tag,
    output logic              o_valid,
    output hfam_pkg::t_tag    o_tag,
    output logic [15:0]       o_res
);

    // stage 1: decode, align or multiply
    logic [10:0] ma, mb;
    logic [4:0]  ea, eb;
    logic [21:0] prod;
    logic [hfam_pkg::ALIGN_W-1:0] n_x, n_y;
    logic signed [7:0] n_t1;

    logic                         r_v1;
    hfam_pkg::t_tag               r_tag1;
    logic [hfam_pkg::ALIGN_W-1:0] r_x1, r_y1;
    logic                         r_sa1, r_sb1;
    logic signed [7:0]            r_t1;

    always_comb begin
        ea   = i_tag.a[14:10];
        eb   = i_tag.b[14:10];
        ma   = (i_tag.a[14:0] == 15'd0) ? 11'd0 : {1'b1, i_tag.a[9:0]};
        mb   = (i_tag.b[14:0] == 15'd0) ? 11'd0 : {1'b1, i_tag.b[9:0]};
        prod = {11'd0, ma} * {11'd0, mb};
        if (i_tag.mode == hfam_pkg::MODE_MUL) begin
            n_x  = {{(hfam_pkg::ALIGN_W-22){1'b0}}, prod};
            n_y  = '0;
            n_t1 = $signed({3'd0, ea}) + $signed({3'd0, eb}) - hfam_pkg::MUL_BIAS;
        end else begin
            n_x  = {{(hfam_pkg::ALIGN_W-11){1'b0}}, ma} << ea;
            n_y  = {{(hfam_pkg::ALIGN_W-11){1'b0}}, mb} << eb;
            n_t1 = hfam_pkg::ADD_EOFS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_tag1 <= i_tag;
            r_x1   <= n_x;
            r_y1   <= n_y;
            r_sa1  <= i_tag.a[15];
            r_sb1  <= i_tag.b[15];
            r_t1   <= n_t1;
        end
    end

    // stage 2: signed magnitude add
    logic [hfam_pkg::SUM_W-1:0] n_s2, xe, ye;
    logic                       n_sg2;

    logic                       r_v2;
    hfam_pkg::t_tag             r_tag2;
    logic [hfam_pkg::SUM_W-1:0] r_s2;
    logic                       r_sg2;
    logic signed [7:0]          r_t2;

    always_comb begin
        xe = {1'b0, r_x1};
        ye = {1'b0, r_y1};
        if (r_tag1.mode == hfam_pkg::MODE_MUL) begin
            n_s2  = xe;
            n_sg2 = r_sa1 ^ r_sb1;
        end else if (r_sa1 == r_sb1) begin
            n_s2  = xe + ye;
            n_sg2 = r_sa1;
        end else if (xe >= ye) begin
            n_s2  = xe - ye;
            n_sg2 = r_sa1;
        end else begin
            n_s2  = ye - xe;
            n_sg2 = r_sb1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_tag2 <= r_tag1;
            r_s2   <= n_s2;
            r_sg2  <= n_sg2;
            r_t2   <= r_t1;
        end
    end

    // stage 3: leading one position
    logic [5:0] n_p3;

    always_comb begin
        n_p3 = '0;
        for (int i = 0; i < hfam_pkg::SUM_W; i++) begin
            if (r_s2[i]) begin
                n_p3 = 6'(i);
            end
        end
    end

    logic                       r_v3;
    hfam_pkg::t_tag             r_tag3;
    logic [hfam_pkg::SUM_W-1:0] r_s3;
    logic                       r_sg3;
    logic signed [7:0]          r_t3;
    logic [5:0]                 r_p3;
    logic                       r_nz3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_tag3 <= r_tag2;
            r_s3   <= r_s2;
            r_sg3  <= r_sg2;
            r_t3   <= r_t2;
            r_p3   <= n_p3;
            r_nz3  <= (r_s2 != '0);
        end
    end

    // stage 4: normalize, round, pack
    logic [hfam_pkg::SUM_W-1:0] norm;
    logic [11:0]                rnd;
    logic signed [7:0]          ex;
    logic [15:0]                n_res;

    always_comb begin
        norm = r_s3 << (6'(hfam_pkg::SUM_W - 1) - r_p3);
        rnd  = {1'b0, norm[hfam_pkg::SUM_W-1 -: 11]} + {11'd0, norm[hfam_pkg::SUM_W-12]};
        ex   = $signed({2'd0, r_p3}) + r_t3 + $signed({7'd0, rnd[11]});
        if (!r_nz3 || ex < 0) begin
            n_res = '0;
        end else if (ex > $signed({3'd0, hfam_pkg::EXP_MAX})) begin
            n_res = {r_sg3, hfam_pkg::EXP_MAX, hfam_pkg::FRAC_ONES};
        end else begin
            n_res = {r_sg3, ex[4:0], rnd[11] ? 10'd0 : rnd[9:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v3;
        end
        if (i_en) begin
            o_tag <= r_tag3;
            o_res <= n_res;
        end
    end

endmodule

// ----- tb/half_float_add_mul_queue_test.sv -----
// Self-checking testbench for half_float_add_mul_queue: random and directed items, stream stalls.
module half_float_add_mul_queue_test;

    class queue_scoreboard;
        logic [47:0] add_store [hfam_pkg::RING_DEPTH];
        logic [47:0] mul_store [hfam_pkg::RING_DEPTH];
        int add_wr, add_rd, mul_wr, mul_rd;
        logic [47:0] pending_pops [$];
        int mismatches;
        int pops_seen;

        function new();
            foreach (add_store[i]) begin
                add_store[i] = '0;
                mul_store[i] = '0;
            end
            add_wr = 0; add_rd = 0; mul_wr = 0; mul_rd = 0;
            mismatches = 0;
            pops_seen = 0;
        endfunction

        function real half_to_real(logic [15:0] h);
            logic [63:0] bits;
            logic [10:0] ee;
            if (h[14:10] == 5'd0)
                ee = (h[9:0] == 10'd0) ? 11'd0 : 11'd1008;
            else
                ee = {6'd0, h[14:10]} + 11'd1008;
            bits = {h[15], ee, h[9:0], 42'd0};
            return $bitstoreal(bits);
        endfunction

        function logic [15:0] round_to_half(real v);
            logic [63:0] x;
            int ex;
            logic [9:0] man;
            x = $realtobits(v) + 64'h0000_0200_0000_0000;
            ex = int'(x[62:52]) - 1008;
            man = x[51:42];
            if (ex < 0)
                return 16'h0000;
            if (ex > 31) begin
                ex = 31;
                man = hfam_pkg::FRAC_ONES;
            end
            return {x[63], ex[4:0], man};
        endfunction

        function void note_item(hfam_pkg::t_mode mode, logic [15:0] a, logic [15:0] b,
                                logic rd);
            real va, vb;
            logic [15:0] r;
            logic [47:0] entry;
            va = half_to_real(a);
            vb = half_to_real(b);
            r = round_to_half(mode == hfam_pkg::MODE_MUL ? va * vb : va + vb);
            entry = {b, a, r};
            if (mode == hfam_pkg::MODE_MUL) begin
                mul_store[mul_wr] = entry;
                mul_wr = (mul_wr + 1) % hfam_pkg::RING_DEPTH;
                if (rd) begin
                    pending_pops.push_back(mul_store[mul_rd]);
                    mul_rd = (mul_rd + 1) % hfam_pkg::RING_DEPTH;
                end
            end else begin
                add_store[add_wr] = entry;
                add_wr = (add_wr + 1) % hfam_pkg::RING_DEPTH;
                if (rd) begin
                    pending_pops.push_back(add_store[add_rd]);
                    add_rd = (add_rd + 1) % hfam_pkg::RING_DEPTH;
                end
            end
        endfunction

        function void check_pop(logic [47:0] got);
            logic [47:0] exp_e;
            pops_seen++;
            if (pending_pops.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected pop %h", got);
                return;
            end
            exp_e = pending_pops.pop_front();
            if (got[15:0] !== exp_e[15:0] || got[31:16] !== exp_e[31:16]
                || got[47:32] !== exp_e[47:32]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result/a/b expected %h %h %h got %h %h %h",
                             exp_e[15:0], exp_e[31:16], exp_e[47:32],
                             got[15:0], got[31:16], got[47:32]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;  // mode, a_bits, b_bits, read_enable, zero pad
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;       // result_bits, a_echo, b_echo

    queue_scoreboard sb = new();
    int phase = 0;        // 0: receiver idles more, 1: sender idles more, 2: no idling after a receiver hold-off
    bit hold_off = 1'b0;
    int items_sent = 0;

    always #1 i_clk = ~i_clk;

    half_float_add_mul_queue DUT (.*);

    function logic [15:0] pick_half();
        logic [4:0] ex;
        logic [9:0] fr;
        case ($urandom_range(0, 5))
            0: ex = 5'd0;
            1: ex = hfam_pkg::EXP_MAX;
            default: ex = 5'($urandom_range(0, 31));
        endcase
        case ($urandom_range(0, 5))
            0: fr = 10'd0;
            1: fr = hfam_pkg::FRAC_ONES;
            default: fr = 10'($urandom_range(0, 1023));
        endcase
        return {1'($urandom_range(0, 1)), ex, fr};
    endfunction

    task send_item(hfam_pkg::t_mode mode, logic [15:0] a, logic [15:0] b, logic rd);
        while (phase != 2 && $urandom_range(0, 99) < (phase == 0 ? 35 : 70)) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata = 40'({$urandom, $urandom});
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {6'd0, rd, b, a, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_item(mode, a, b, rd);
        items_sent++;
    endtask

    always @(negedge i_clk) begin
        if (hold_off)
            i_m_axis_tready <= 1'b0;
        else if (phase == 2)
            i_m_axis_tready <= 1'b1;
        else
            i_m_axis_tready <= $urandom_range(0, 99) >= (phase == 0 ? 70 : 35);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_pop(o_m_axis_tdata);
    end

    initial begin
        #4000000;
        $display("FAIL half_float_add_mul_queue");
        $finish;
    end

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pop from fresh rings, signed zeros, tiny values, saturation, underflow
        send_item(hfam_pkg::MODE_ADD, 16'h0000, 16'h8000, 1'b1);
        send_item(hfam_pkg::MODE_MUL, 16'h8000, 16'h8000, 1'b1);
        send_item(hfam_pkg::MODE_ADD, 16'h8000, 16'h8000, 1'b1);
        send_item(hfam_pkg::MODE_ADD, 16'h0001, 16'h0000, 1'b1);
        send_item(hfam_pkg::MODE_MUL, 16'h03ff, 16'h3c00, 1'b1);
        send_item(hfam_pkg::MODE_ADD, 16'h7fff, 16'h7fff, 1'b1);
        send_item(hfam_pkg::MODE_ADD, 16'hffff, 16'hffff, 1'b1);
        send_item(hfam_pkg::MODE_MUL, 16'h7fff, 16'hffff, 1'b1);
        send_item(hfam_pkg::MODE_MUL, 16'h0400, 16'h0400, 1'b1);
        send_item(hfam_pkg::MODE_MUL, 16'h3800, 16'h0000, 1'b1);
        send_item(hfam_pkg::MODE_MUL, 16'h3800, 16'h0001, 1'b1);
        send_item(hfam_pkg::MODE_ADD, 16'h3c00, 16'hbc00, 1'b1);
        send_item(hfam_pkg::MODE_ADD, 16'h3c00, 16'h1000, 1'b1);
        send_item(hfam_pkg::MODE_ADD, 16'h3c01, 16'h1400, 1'b1);
        send_item(hfam_pkg::MODE_MUL, 16'h3c01, 16'h3c01, 1'b1);
        send_item(hfam_pkg::MODE_ADD, 16'h7c00, 16'h0001, 1'b1);
        // overfill the add ring, then drain past its fill level
        for (int i = 0; i < 13; i++)
            send_item(hfam_pkg::MODE_ADD, pick_half(), pick_half(), 1'b0);
        for (int i = 0; i < 12; i++)
            send_item(hfam_pkg::MODE_ADD, pick_half(), pick_half(), 1'b1);

        for (int p = 0; p < 3; p++) begin
            phase = p;
            if (p == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            n = 0;
            while (n < 575) begin
                send_item(hfam_pkg::t_mode'($urandom_range(0, 1)), pick_half(), pick_half(),
                          1'($urandom_range(0, 99) < 60));
                n++;
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        while (sb.pending_pops.size() != 0 || hold_off) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Covered %0d items, %0d popped results, both modes, rings overfilled and drained",
                 items_sent, sb.pops_seen);
        $display("Stalls on both sides and one long receiver hold-off; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS half_float_add_mul_queue");
        else
            $display("FAIL half_float_add_mul_queue");
        $finish;
    end
endmodule
